/* design/olss_pkg.sv */
`timescale 1ns / 1ps
package olss_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam logic [2:0] FUNC_PUSH     = 3'd0;
    localparam logic [2:0] FUNC_APPEND   = 3'd1;
    localparam logic [2:0] FUNC_REMOVE   = 3'd2;
    localparam logic [2:0] FUNC_CONTAINS = 3'd3;
    localparam logic [2:0] FUNC_POP      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [31:0]      popped_value;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic [1:0]       status;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_SHIFT_IN  = 3'd1,
        CELL_SHIFT_OUT = 3'd2,
        CELL_CLOSE     = 3'd3,
        CELL_APPEND    = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [VALUE_WIDTH-1:0] key;
    } cell_ctrl_t;

endpackage

/* design/olss_cell.sv */
`timescale 1ns / 1ps
module olss_cell (
    input  logic                            clk,
    input  olss_pkg::cell_ctrl_t            ctrl,
    input  logic                            in_range,
    input  logic                            at_tail,
    input  logic                            match_in,
    input  logic [olss_pkg::VALUE_WIDTH-1:0] left_val,
    input  logic [olss_pkg::VALUE_WIDTH-1:0] right_val,
    output logic [olss_pkg::VALUE_WIDTH-1:0] value,
    output logic                            match_out
);
    import olss_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;

    // first-match chain: set from the first valid cell holding the key onward
    assign match_out = match_in | (in_range && (value_reg == ctrl.key));
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_SHIFT_IN:  value_next = left_val;
            CELL_SHIFT_OUT: value_next = right_val;
            CELL_CLOSE:     value_next = match_out ? right_val : value_reg;
            CELL_APPEND:    value_next = at_tail ? ctrl.key : value_reg;
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* design/ordered_list_store_unit.sv */
`timescale 1ns / 1ps
// An accepted request is registered; cells and result register then update together,
// waiting on a held, untaken result. The row of cells runs one request at a time.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n, async, active low) empties the list and clears handshake state.
// Stored values are not reset; only entries below the count are ever read.
module ordered_list_store_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  olss_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output olss_pkg::rsp_t out_data
);
    import olss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } fsm_t;

    fsm_t             state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_data_reg, out_data_next;

    cell_ctrl_t             ctrl;
    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic                   match_chain [DEPTH+1];

    logic in_fire, exec_fire, full, empty, found;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign found     = match_chain[DEPTH];

    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_v, right_v;
            if (gi == 0)
            begin : g_first
                assign left_v = ctrl.key;
            end
            else
            begin : g_mid
                assign left_v = cell_val[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_v = cell_val[gi];
            end
            else
            begin : g_notlast
                assign right_v = cell_val[gi+1];
            end

            olss_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .in_range  (CNT_W'(gi) < occ_reg),
                .at_tail   (CNT_W'(gi) == occ_reg),
                .match_in  (match_chain[gi]),
                .left_val  (left_v),
                .right_val (right_v),
                .value     (cell_val[gi]),
                .match_out (match_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.key       = req_reg.item_value[VALUE_WIDTH-1:0];
        ctrl.op        = CELL_HOLD;
        occ_next       = occ_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        state_next     = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    out_data_next.hit          = 1'b0;
                    out_data_next.popped_value = '0;
                    out_data_next.status       = STATUS_OK;
                    case (req_reg.func)
                        FUNC_PUSH, FUNC_APPEND:
                        begin
                            if (full)
                            begin
                                out_data_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op = (req_reg.func == FUNC_PUSH) ? CELL_SHIFT_IN
                                                                      : CELL_APPEND;
                                occ_next = occ_reg + 1'b1;
                                out_data_next.hit = 1'b1;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (found)
                            begin
                                ctrl.op  = CELL_CLOSE;
                                occ_next = occ_reg - 1'b1;
                            end
                            out_data_next.hit = found;
                        end
                        FUNC_CONTAINS:
                        begin
                            out_data_next.hit = found;
                        end
                        FUNC_POP:
                        begin
                            if (empty)
                            begin
                                out_data_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                ctrl.op  = CELL_SHIFT_OUT;
                                occ_next = occ_reg - 1'b1;
                                out_data_next.hit          = 1'b1;
                                out_data_next.popped_value = 32'(cell_val[0]);
                            end
                        end
                        default:
                        begin
                            ctrl.op = CELL_HOLD;
                        end
                    endcase
                    out_data_next.entry_count = occ_next;
                    out_data_next.is_empty    = (occ_next == '0);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/olss_checker.sv */
`timescale 1ns / 1ps
module olss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input olss_pkg::req_t in_data,
    input logic           out_valid,
    input logic           out_ready,
    input olss_pkg::rsp_t out_data
);
    import olss_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another executes");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_FULL |->
            !out_data.hit && out_data.entry_count == CNT_W'(DEPTH))
        else $error("full rejection with wrong count");

    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_EMPTY |->
            !out_data.hit && out_data.is_empty && out_data.popped_value == '0)
        else $error("empty pop reported wrongly");

endmodule

bind ordered_list_store_unit olss_checker u_olss_checker (.*);

/* verif/ordered_list_store_unit_test.sv */
`timescale 1ns / 1ps
module ordered_list_store_unit_test;
    import olss_pkg::*;

    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    localparam int RANDOM_REQS = 1600;
    localparam int DRAIN_AT    = 800;
    localparam int LONG_HOLD   = 80;
    localparam int HOLD_AT     = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int N_ROWS      = 19;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
        logic [7:0]  reps;
        logic        known;
        rsp_t        want;
    } dir_row_t;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data  = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    rsp_t out_data;

    logic [31:0] list_vals [DEPTH];
    int          list_len = 0;
    rsp_t        pending_rsps [$];
    logic [31:0] val_pool [8];
    int          mismatches = 0;
    int          rsp_seen = 0;
    int          idle_cycles = 0;
    bit          snd_quiet = 1'b0;

    // expected result typed only where obvious; a row with known clear uses the predictor
    dir_row_t dir_rows [N_ROWS] = '{
        '{FUNC_POP,      32'h0000_0000, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd0,  1'b1, STATUS_EMPTY}},
        '{FUNC_CONTAINS, 32'h0000_0000, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd0,  1'b1, STATUS_OK}},
        '{FUNC_REMOVE,   32'hFFFF_FFFF, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd0,  1'b1, STATUS_OK}},
        '{FUNC_SPARE5,   32'h1234_5678, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd0,  1'b1, STATUS_OK}},
        '{FUNC_PUSH,     32'hFFFF_FFFF, 8'd1, 1'b1, '{1'b1, 32'h0, 5'd1,  1'b0, STATUS_OK}},
        '{FUNC_PUSH,     32'h0000_0000, 8'd1, 1'b1, '{1'b1, 32'h0, 5'd2,  1'b0, STATUS_OK}},
        '{FUNC_CONTAINS, 32'hFFFF_FFFF, 8'd1, 1'b1, '{1'b1, 32'h0, 5'd2,  1'b0, STATUS_OK}},
        '{FUNC_APPEND,   32'h5555_5555, 8'd7, 1'b0, '0},
        '{FUNC_APPEND,   32'hAAAA_AAAA, 8'd7, 1'b0, '0},
        '{FUNC_PUSH,     32'h0F0F_0F0F, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd16, 1'b0, STATUS_FULL}},
        '{FUNC_APPEND,   32'hF0F0_F0F0, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd16, 1'b0, STATUS_FULL}},
        '{FUNC_SPARE6,   32'hFFFF_FFFF, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd16, 1'b0, STATUS_OK}},
        '{FUNC_SPARE7,   32'h0000_0000, 8'd1, 1'b1, '{1'b0, 32'h0, 5'd16, 1'b0, STATUS_OK}},
        '{FUNC_CONTAINS, 32'h8000_0001, 8'd1, 1'b0, '0},
        '{FUNC_REMOVE,   32'hAAAA_AAAA, 8'd1, 1'b0, '0},
        '{FUNC_REMOVE,   32'hFFFF_FFFF, 8'd1, 1'b0, '0},
        '{FUNC_REMOVE,   32'h7777_7777, 8'd1, 1'b0, '0},
        '{FUNC_POP,      32'hFFFF_FFFF, 8'd1, 1'b0, '0},
        '{FUNC_POP,      32'h0000_0000, 8'd1, 1'b0, '0}
    };

    ordered_list_store_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        int   pos;
        res = '0;
        case (r.func)
            FUNC_PUSH, FUNC_APPEND:
            begin
                if (list_len >= DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    if (r.func == FUNC_PUSH)
                    begin
                        for (int i = list_len; i > 0; i--)
                            list_vals[i] = list_vals[i - 1];
                        list_vals[0] = r.item_value;
                    end
                    else
                        list_vals[list_len] = r.item_value;
                    list_len++;
                    res.hit = 1'b1;
                end
            end
            FUNC_REMOVE, FUNC_CONTAINS:
            begin
                pos = list_len;
                for (int i = list_len - 1; i >= 0; i--)
                    if (list_vals[i] == r.item_value)
                        pos = i;
                if (pos < list_len)
                begin
                    res.hit = 1'b1;
                    if (r.func == FUNC_REMOVE)
                    begin
                        for (int i = pos; i + 1 < list_len; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_len--;
                    end
                end
            end
            FUNC_POP:
            begin
                if (list_len == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.popped_value = list_vals[0];
                    for (int i = 0; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                    res.hit = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = CNT_W'(list_len);
        res.is_empty    = (list_len == 0);
        return res;
    endfunction

    task automatic send_req(input req_t r, input logic known, input rsp_t want);
        rsp_t got;
        in_data  <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        got = apply_request(r);
        pending_rsps.push_back(known ? want : got);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int k;
        int gap;
        k = $urandom_range(0, 99);
        gap = 0;
        if (!snd_quiet)
        begin
            if (k >= 92)
                gap = $urandom_range(8, 40);
            else if (k >= 60)
                gap = $urandom_range(1, 3);
        end
        if ($urandom_range(0, 149) == 0)
            snd_quiet = !snd_quiet;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        req_t        r;
        logic [31:0] v;
        int          k;
        int          grow;
        bit          filling;
        val_pool[0] = 32'h0000_0000;
        val_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            val_pool[i] = $urandom;
        filling = 1'b1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < N_ROWS; n++)
            for (int j = 0; j < dir_rows[n].reps; j++)
            begin
                r.func       = dir_rows[n].func;
                r.item_value = dir_rows[n].value;
                send_req(r, dir_rows[n].known, dir_rows[n].want);
                sender_gap();
            end

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (list_len >= DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (list_len == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            grow = filling ? 55 : 25;
            k = $urandom_range(0, 99);
            if (k < 3)
            begin
                case ($urandom_range(0, 2))
                    0: r.func = FUNC_SPARE5;
                    1: r.func = FUNC_SPARE6;
                    default: r.func = FUNC_SPARE7;
                endcase
            end
            else if (k < 18)
                r.func = FUNC_CONTAINS;
            else if (k < 18 + grow)
                r.func = $urandom_range(0, 1) ? FUNC_PUSH : FUNC_APPEND;
            else
                r.func = $urandom_range(0, 1) ? FUNC_REMOVE : FUNC_POP;

            k = $urandom_range(0, 99);
            if ((r.func == FUNC_REMOVE || r.func == FUNC_CONTAINS) && list_len > 0 && k < 40)
                v = list_vals[$urandom_range(0, list_len - 1)];
            else if (k < 70)
                v = val_pool[$urandom_range(0, 7)];
            else
                v = $urandom;
            r.item_value = v;

            send_req(r, 1'b0, '0);
            if (n == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                while (pending_rsps.size() != 0)
                    @(negedge clk);
            end
            else if (n != RANDOM_REQS - 1)
                sender_gap();
        end

        in_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off to back the block up
    initial
    begin
        int  stall_left;
        int  k;
        bit  held_long;
        bit  rcv_quiet;
        stall_left = 0;
        held_long  = 1'b0;
        rcv_quiet  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_long && rsp_seen >= HOLD_AT)
            begin
                held_long  = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !rcv_quiet)
            begin
                k = $urandom_range(0, 99);
                if (k < 25)
                    stall_left = $urandom_range(1, 3);
                else if (k < 28)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 299) == 0)
                rcv_quiet = !rcv_quiet;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            rsp_seen++;
            if (pending_rsps.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (out_data.hit !== want.hit)
                begin
                    $display("%0t: hit exp %0d got %0d", $time, want.hit, out_data.hit);
                    mismatches++;
                end
                if (out_data.popped_value !== want.popped_value)
                begin
                    $display("%0t: popped_value exp %h got %h", $time,
                             want.popped_value, out_data.popped_value);
                    mismatches++;
                end
                if (out_data.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             want.entry_count, out_data.entry_count);
                    mismatches++;
                end
                if (out_data.is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty exp %0d got %0d", $time,
                             want.is_empty, out_data.is_empty);
                    mismatches++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time,
                             want.status, out_data.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
